FILE: rtl/pid_variable_timestep_core_macros.svh
// Assertion macros for the PID variable time step core.
`ifndef PID_VARIABLE_TIMESTEP_CORE_MACROS_SVH
`define PID_VARIABLE_TIMESTEP_CORE_MACROS_SVH

// Next-cycle implication.
`define PVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvt assertion failed");

// Same-cycle implication.
`define PVT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvt assertion failed");

`endif

FILE: rtl/pvt_pkg.sv
// Shared types, constants and functions of the PID variable time step core.
package pvt_pkg;

   localparam int DataW    = 32;
   localparam int ProdW    = 66;
   localparam int QuoW     = 65;
   localparam int DivSteps = 65;
   localparam int CntW     = 7;
   localparam int AddrW    = 4;
   localparam int FracW    = 16;

   localparam logic signed [ProdW-1:0] SatMax = 66'sd2147483647;
   localparam logic signed [ProdW-1:0] SatMin = -66'sd2147483648;

   typedef enum logic [1:0] {
      REG_KP = 2'd0,
      REG_KI = 2'd1,
      REG_KD = 2'd2
   } pvt_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ERR, ST_P_MUL, ST_P_SAT, ST_KE_MUL, ST_KE_SAT, ST_INC_MUL,
      ST_INC_ADD, ST_D_MUL, ST_D_PREP, ST_DIV, ST_D_SAT, ST_SUM, ST_OUT
   } pvt_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_ERR, OP_P_MUL, OP_P_SAT, OP_KE_MUL, OP_KE_SAT,
      OP_INC_MUL, OP_INC_ADD, OP_D_MUL, OP_D_PREP, OP_DIV, OP_D_SAT, OP_SUM,
      OP_OUT
   } pvt_op_type;

   typedef struct packed {
      pvt_op_type op;
   } pvt_cmd_type;

   typedef struct packed {
      logic advance;
   } pvt_status_type;

   function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] v);
      if (v > SatMax) begin
         return SatMax[DataW-1:0];
      end else if (v < SatMin) begin
         return SatMin[DataW-1:0];
      end else begin
         return v[DataW-1:0];
      end
   endfunction

endpackage

FILE: rtl/pvt_req_if.sv
// Request channel: setpoint, measurement and timestamp.
interface pvt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_value;
   logic signed [31:0] measured_input;
   logic        [31:0] sample_time;

   modport source (output valid, target_value, measured_input, sample_time, input ready);
   modport sink   (input valid, target_value, measured_input, sample_time, output ready);
endinterface

FILE: rtl/pvt_rsp_if.sv
// Response channel: drive command.
interface pvt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive_command;

   modport source (output valid, drive_command, input ready);
   modport sink   (input valid, drive_command, output ready);
endinterface

FILE: rtl/pvt_regs.sv
// APB gain registers.
module pvt_regs
   import pvt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [AddrW-1:0]        paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   output logic signed [DataW-1:0] gain_kp,
   output logic signed [DataW-1:0] gain_ki,
   output logic signed [DataW-1:0] gain_kd
);

   logic signed [DataW-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic                    wr_en;
   pvt_reg_type             idx;

   assign wr_en = psel && penable && pwrite;
   assign idx   = pvt_reg_type'(paddr[3:2]);
   assign pready = 1'b1;

   always_comb begin
      kp_in = kp_ff;
      ki_in = ki_ff;
      kd_in = kd_ff;
      if (wr_en) begin
         case (idx)
            REG_KP:  kp_in = pwdata;
            REG_KI:  ki_in = pwdata;
            REG_KD:  kd_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_KP:  prdata = kp_ff;
         REG_KI:  prdata = ki_ff;
         REG_KD:  prdata = kd_ff;
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
      end else begin
         kp_ff <= kp_in;
         ki_ff <= ki_in;
         kd_ff <= kd_in;
      end
   end

   assign gain_kp = kp_ff;
   assign gain_ki = ki_ff;
   assign gain_kd = kd_ff;

endmodule

FILE: rtl/pvt_ctrl.sv
// Sequencer for the PID datapath and response valid.
module pvt_ctrl
   import pvt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  pvt_status_type status,
   output pvt_cmd_type    cmd
);

   pvt_state_type   state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_ERR;
         ST_ERR:     state_in = ST_P_MUL;
         ST_P_MUL:   state_in = ST_P_SAT;
         ST_P_SAT:   state_in = status.advance ? ST_KE_MUL : ST_SUM;
         ST_KE_MUL:  state_in = ST_KE_SAT;
         ST_KE_SAT:  state_in = ST_INC_MUL;
         ST_INC_MUL: state_in = ST_INC_ADD;
         ST_INC_ADD: state_in = ST_D_MUL;
         ST_D_MUL:   state_in = ST_D_PREP;
         ST_D_PREP:  state_in = ST_DIV;
         ST_DIV:     if (cnt_ff == CntW'(DivSteps - 1)) state_in = ST_D_SAT;
         ST_D_SAT:   state_in = ST_SUM;
         ST_SUM:     state_in = ST_OUT;
         ST_OUT:     if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = OP_NONE;
      req_ready    = 1'b0;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_ERR:     cmd.op = OP_ERR;
         ST_P_MUL:   cmd.op = OP_P_MUL;
         ST_P_SAT:   cmd.op = OP_P_SAT;
         ST_KE_MUL:  cmd.op = OP_KE_MUL;
         ST_KE_SAT:  cmd.op = OP_KE_SAT;
         ST_INC_MUL: cmd.op = OP_INC_MUL;
         ST_INC_ADD: cmd.op = OP_INC_ADD;
         ST_D_MUL:   cmd.op = OP_D_MUL;
         ST_D_PREP: begin
            cmd.op = OP_D_PREP;
            cnt_in = '0;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_D_SAT:   cmd.op = OP_D_SAT;
         ST_SUM:     cmd.op = OP_SUM;
         ST_OUT: begin
            if (slot_free) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/pvt_dp.sv
// PID datapath: shared multiplier, radix-2 divider, state and result register.
module pvt_dp
   import pvt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  pvt_cmd_type             cmd,
   output pvt_status_type          status,
   input  logic signed [DataW-1:0] gain_kp,
   input  logic signed [DataW-1:0] gain_ki,
   input  logic signed [DataW-1:0] gain_kd,
   input  logic signed [DataW-1:0] target_value,
   input  logic signed [DataW-1:0] measured_input,
   input  logic        [DataW-1:0] sample_time,
   output logic signed [DataW-1:0] drive_command
);

   logic signed [DataW-1:0] sp_ff, sp_in, mv_ff, mv_in, err_ff, err_in;
   logic        [DataW-1:0] t_ff, t_in, last_t_ff, last_t_in;
   logic signed [DataW-1:0] last_err_ff, last_err_in, integ_ff, integ_in;
   logic signed [DataW-1:0] p_ff, p_in, ke_ff, ke_in, d_ff, d_in;
   logic signed [DataW-1:0] sum_ff, sum_in, out_ff, out_in;
   logic                    has_prev_ff, has_prev_in, neg_ff, neg_in;
   logic signed [ProdW-1:0] prod_ff, prod_in, prod_shr, prod_abs;
   logic        [QuoW-1:0]  quo_ff, quo_in;
   logic        [DataW-1:0] rem_ff, rem_in, dt;
   logic signed [DataW:0]   mul_a, mul_b, de;
   logic        [DataW:0]   rem_shift;
   logic        [DataW+1:0] rem_diff;
   logic signed [ProdW-1:0] q_signed;

   assign dt             = t_ff - last_t_ff;
   assign de             = {err_ff[DataW-1], err_ff} - {last_err_ff[DataW-1], last_err_ff};
   assign status.advance = has_prev_ff && (t_ff > last_t_ff);
   assign prod_shr       = prod_ff >>> FracW;
   assign prod_abs       = prod_ff[ProdW-1] ? -prod_ff : prod_ff;
   assign rem_shift      = {rem_ff, quo_ff[QuoW-1]};
   assign rem_diff       = {1'b0, rem_shift} - {2'b00, dt};
   assign q_signed       = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   always_comb begin
      case (cmd.op)
         OP_KE_MUL: begin
            mul_a = {gain_ki[DataW-1], gain_ki};
            mul_b = {err_ff[DataW-1], err_ff};
         end
         OP_INC_MUL: begin
            mul_a = {ke_ff[DataW-1], ke_ff};
            mul_b = {1'b0, dt};
         end
         OP_D_MUL: begin
            mul_a = {gain_kd[DataW-1], gain_kd};
            mul_b = de;
         end
         default: begin
            mul_a = {gain_kp[DataW-1], gain_kp};
            mul_b = {err_ff[DataW-1], err_ff};
         end
      endcase
   end

   always_comb begin
      sp_in       = sp_ff;
      mv_in       = mv_ff;
      t_in        = t_ff;
      err_in      = err_ff;
      last_t_in   = last_t_ff;
      last_err_in = last_err_ff;
      integ_in    = integ_ff;
      has_prev_in = has_prev_ff;
      p_in        = p_ff;
      ke_in       = ke_ff;
      d_in        = d_ff;
      sum_in      = sum_ff;
      out_in      = out_ff;
      neg_in      = neg_ff;
      prod_in     = prod_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      case (cmd.op)
         OP_LOAD: begin
            sp_in = target_value;
            mv_in = measured_input;
            t_in  = sample_time;
         end
         OP_ERR: begin
            err_in = sat32(ProdW'(sp_ff) - ProdW'(mv_ff));
            d_in   = '0;
         end
         OP_P_MUL, OP_KE_MUL, OP_INC_MUL, OP_D_MUL: prod_in = mul_a * mul_b;
         OP_P_SAT:   p_in = sat32(prod_shr);
         OP_KE_SAT:  ke_in = sat32(prod_shr);
         OP_INC_ADD: integ_in = sat32(ProdW'(integ_ff) + prod_shr);
         OP_D_PREP: begin
            neg_in = prod_ff[ProdW-1];
            quo_in = prod_abs[QuoW-1:0];
            rem_in = '0;
         end
         OP_DIV: begin
            if (!rem_diff[DataW+1]) begin
               rem_in = rem_diff[DataW-1:0];
               quo_in = {quo_ff[QuoW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DataW-1:0];
               quo_in = {quo_ff[QuoW-2:0], 1'b0};
            end
         end
         OP_D_SAT: d_in = sat32(q_signed);
         OP_SUM: begin
            sum_in      = sat32(ProdW'(p_ff) + ProdW'(integ_ff) + ProdW'(d_ff));
            last_t_in   = t_ff;
            last_err_in = err_ff;
            has_prev_in = 1'b1;
         end
         OP_OUT:  out_in = sum_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_prev_ff <= 1'b0;
         last_t_ff   <= '0;
         last_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         has_prev_ff <= has_prev_in;
         last_t_ff   <= last_t_in;
         last_err_ff <= last_err_in;
         integ_ff    <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff   <= sp_in;
      mv_ff   <= mv_in;
      t_ff    <= t_in;
      err_ff  <= err_in;
      p_ff    <= p_in;
      ke_ff   <= ke_in;
      d_ff    <= d_in;
      sum_ff  <= sum_in;
      out_ff  <= out_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign drive_command = out_ff;

endmodule

FILE: rtl/pid_variable_timestep_core.sv
// PID regulator with variable time step, signed Q16.16: top level.
//
// Request beats carry target_value, measured_input and sample_time; each
// request yields one response beat with the saturated drive_command.
// Gains Kp, Ki, Kd are written over the APB port at byte addresses 0, 4, 8.
// One request is processed at a time; req_chan.ready is high only when idle.
// A step on the first sample or when time did not advance skips the
// integral and derivative updates. A full step's length is set mostly by
// the 65-step radix-2 divider that forms the derivative term (Kd * delta
// error / dt), plus the shared 33x33 multiplier used in four passes.
// The response sits in an output register; a stalled receiver holds the
// beat, and the block finishes the next step and then waits for the slot.
// Synchronous reset clears gains, the integral, stored error and time, and
// the previous-sample flag; no response is pending after reset.
`include "pid_variable_timestep_core_macros.svh"
module pid_variable_timestep_core
   import pvt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   pvt_req_if.sink          req_chan,
   pvt_rsp_if.source        rsp_chan,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [AddrW-1:0] paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic signed [DataW-1:0] gain_kp, gain_ki, gain_kd;
   pvt_cmd_type             cmd;
   pvt_status_type          status;

   pvt_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .gain_kp (gain_kp),
      .gain_ki (gain_ki),
      .gain_kd (gain_kd)
   );

   pvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pvt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .gain_kp        (gain_kp),
      .gain_ki        (gain_ki),
      .gain_kd        (gain_kd),
      .target_value   (req_chan.target_value),
      .measured_input (req_chan.measured_input),
      .sample_time    (req_chan.sample_time),
      .drive_command  (rsp_chan.drive_command)
   );

   `PVT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `PVT_ASSERT_NEXT(a_no_rsp_after_reset, clock, 1'b0, reset, !rsp_chan.valid)
   `PVT_ASSERT_NOW(a_idle_no_op, clock, reset, req_chan.ready && !req_chan.valid, cmd.op == OP_NONE)

endmodule
